[hw/rtl/bwtc_pkg.sv]
// bwtc_pkg: shared types and constants of the 3x3 binary window template counter.
// No dependencies; used by every module of the block.
package bwtc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

    // Field widths
    localparam int TEMPLATE_W = 9;
    localparam int SIZE_W     = 7;
    localparam int ROW_W      = 6;
    localparam int COUNT_W    = 12;

    // Reset values and limits
    localparam logic [TEMPLATE_W-1:0] TEMPLATE_RESET = 9'd16;
    localparam logic [SIZE_W-1:0]     WIDTH_RESET    = 7'd9;
    localparam logic [SIZE_W-1:0]     HEIGHT_RESET   = 7'd9;
    localparam logic [SIZE_W-1:0]     SIZE_MIN       = 7'd3;
    localparam logic [SIZE_W-1:0]     HEIGHT_LIMIT   = 7'd64;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 12'd4095;

    // Per-pixel flags set by the front part
    typedef struct packed {
        logic pixel;
        logic win_ok;
        logic frame_end;
    } t_flags;

endpackage

[hw/rtl/bwtc_front.sv]
// bwtc_front: configuration registers and raster position tracking; tags each pixel
// with window-complete and end-of-frame flags. Depends on bwtc_pkg.
module bwtc_front import bwtc_pkg::*; #(
    parameter int MAX_WIDTH = 64,
    parameter int COL_W     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_pixel,
    output t_flags                o_flags,
    output logic [COL_W-1:0]      o_col,
    output logic [TEMPLATE_W-1:0] o_template
);

    localparam int SW = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;

    logic [TEMPLATE_W-1:0] r_template;
    logic [SIZE_W-1:0]     r_width;
    logic [SIZE_W-1:0]     r_height;
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic [SW-1:0]         width_ext;
    logic [SW-1:0]         width_use;
    logic [SIZE_W-1:0]     height_use;
    logic                  last_col;
    logic                  last_row;

    // Write configuration registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_template <= TEMPLATE_RESET;
            r_width    <= WIDTH_RESET;
            r_height   <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMPLATE: r_template <= i_cfg_data[TEMPLATE_W-1:0];
                REG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Saturate sizes to their usable range
    always_comb begin
        width_ext = SW'(r_width);
        if (width_ext < SW'(SIZE_MIN)) begin
            width_use = SW'(SIZE_MIN);
        end else if (width_ext > SW'(MAX_WIDTH)) begin
            width_use = SW'(MAX_WIDTH);
        end else begin
            width_use = width_ext;
        end
        if (r_height < SIZE_MIN) begin
            height_use = SIZE_MIN;
        end else if (r_height > HEIGHT_LIMIT) begin
            height_use = HEIGHT_LIMIT;
        end else begin
            height_use = r_height;
        end
    end

    // Classify the current position
    assign last_col = (SW'(r_col) + SW'(1)) >= width_use;
    assign last_row = (SIZE_W'(r_row) + SIZE_W'(1)) >= height_use;

    assign o_flags.pixel     = i_pixel;
    assign o_flags.win_ok    = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_flags.frame_end = last_col && last_row;
    assign o_col             = r_col;
    assign o_template        = r_template;

    // Advance the raster position on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_push) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

endmodule

[hw/rtl/bwtc_queue.sv]
// bwtc_queue: short FIFO between the front and back parts.
// Depends on bwtc_pkg for the flag struct.
module bwtc_queue import bwtc_pkg::*; #(
    parameter int COL_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_flags           i_flags,
    input  logic [COL_W-1:0] i_col,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output t_flags           o_flags,
    output logic [COL_W-1:0] o_col
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    t_flags           r_flags [DEPTH];
    logic [COL_W-1:0] r_cols  [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_flags = r_flags[r_rd_ptr];
    assign o_col   = r_cols[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_flags[r_wr_ptr] <= i_flags;
            r_cols[r_wr_ptr]  <= i_col;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

[hw/rtl/bwtc_back.sv]
// bwtc_back: line stores, 3x3 window, template compare and match counter,
// with a read stage and an output register. Depends on bwtc_pkg.
module bwtc_back import bwtc_pkg::*; #(
    parameter int MAX_WIDTH = 64,
    parameter int COL_W     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_flags                i_q_flags,
    input  logic [COL_W-1:0]      i_q_col,
    input  logic [TEMPLATE_W-1:0] i_template,
    output logic                  o_pop,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic                  o_window_match,
    output logic [COUNT_W-1:0]    o_match_count,
    output logic                  o_frame_done
);

    // Line stores: row above and two rows above
    logic                  r_line_a [MAX_WIDTH];
    logic                  r_line_b [MAX_WIDTH];

    logic                  r_s1_valid;
    t_flags                r_s1_flags;
    logic [COL_W-1:0]      r_s1_col;
    logic                  r_up1;
    logic                  r_up2;

    logic [TEMPLATE_W-1:0] r_window;
    logic [COUNT_W-1:0]    r_count;

    logic                  r_out_valid;
    logic                  r_match;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_frame_done;

    logic                  out_free;
    logic                  s1_move;
    logic [TEMPLATE_W-1:0] n_window;
    logic                  hit;
    logic [COUNT_W-1:0]    n_count;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_pop    = !i_q_empty && (!r_s1_valid || out_free);

    // Read both stores at the head column
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_up1      <= r_line_a[i_q_col];
            r_up2      <= r_line_b[i_q_col];
            r_s1_flags <= i_q_flags;
            r_s1_col   <= i_q_col;
        end
    end

    // Shift the column down the stores as the pixel leaves the read stage
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_line_a[r_s1_col] <= r_s1_flags.pixel;
            r_line_b[r_s1_col] <= r_up1;
        end
    end

    // Shift in the new column, compare and count
    always_comb begin
        n_window = {r_s1_flags.pixel, r_up1, r_up2, r_window[TEMPLATE_W-1:3]};
        hit      = r_s1_flags.win_ok && (n_window == i_template);
        n_count  = (hit && (r_count != COUNT_MAX)) ? r_count + COUNT_W'(1) : r_count;
    end

    // Hold stage valids, window and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
            r_count     <= '0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_window    <= n_window;
                r_count     <= r_s1_flags.frame_end ? '0 : n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_match      <= hit;
            r_out_count  <= n_count;
            r_frame_done <= r_s1_flags.frame_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_window_match = r_match;
    assign o_match_count  = r_out_count;
    assign o_frame_done   = r_frame_done;

endmodule

[hw/rtl/binary_window_template_counter_top.sv]
// binary_window_template_counter_top: top level of the 3x3 binary window template counter.
// Depends on bwtc_pkg, bwtc_front, bwtc_queue and bwtc_back.
//
// Usage:
//   Pixels enter in raster order on i_valid/i_pixel; a beat is taken when i_valid is high
//   and o_stall is low. Each pixel gives one result beat on o_valid with o_window_match,
//   o_match_count and o_frame_done, taken when o_valid is high and i_stall is low.
//   The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   index 0 template, 1 image width, 2 image height; o_cfg_ready is always high. Write
//   it only while no pixel is in flight.
//   A result passes through the queue, the line store read stage and the output register
//   before it is presented. Throughput: one pixel per cycle while i_stall does not hold
//   the output, set by the line store read stage that each pixel passes through once.
//   When the receiver stalls, up to six beats are held (four-entry queue, read stage,
//   output register) before o_stall rises; no beat is lost or repeated.
//   Reset clears the raster position, window, match counter and all valids and loads
//   the default template (single centre one) and a 9 x 9 frame. Line stores are not
//   cleared: reads in rows 0 and 1 may see unwritten or stale entries, masked by win_ok.
module binary_window_template_counter_top import bwtc_pkg::*; #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_window_match,
    output logic [COUNT_W-1:0]    o_match_count,
    output logic                  o_frame_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_flags                front_flags;
    logic [COL_W-1:0]      front_col;
    logic [TEMPLATE_W-1:0] template_bits;
    t_flags                q_flags;
    logic [COL_W-1:0]      q_col;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign push        = i_valid && !q_full;

    bwtc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .o_flags     (front_flags),
        .o_col       (front_col),
        .o_template  (template_bits)
    );

    bwtc_queue #(
        .COL_W (COL_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_flags (front_flags),
        .i_col   (front_col),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_flags (q_flags),
        .o_col   (q_col)
    );

    bwtc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_flags      (q_flags),
        .i_q_col        (q_col),
        .i_template     (template_bits),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_window_match (o_window_match),
        .o_match_count  (o_match_count),
        .o_frame_done   (o_frame_done)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for binary_window_template_counter_top (3x3 binary window matcher).
// Depends on bwtc_pkg and the block's RTL; predicts every result beat here and checks it.
module tb;
    import bwtc_pkg::*;

    localparam int MAX_W         = 64;
    localparam int WIDE_ROWS     = 8;
    localparam int RANDOM_PIXELS = 500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PRINT_CAP     = 30;
    // Index past the register list: the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_window_result;

    // Block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  i_pixel     = 1'b0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_window_match;
    logic [COUNT_W-1:0]    o_match_count;
    logic                  o_frame_done;
    logic                  o_cfg_ready;

    // Register copies and raster state of the predictor
    logic [TEMPLATE_W-1:0] tmpl_mirror   = TEMPLATE_RESET;
    logic [SIZE_W-1:0]     width_mirror  = WIDTH_RESET;
    logic [SIZE_W-1:0]     height_mirror = HEIGHT_RESET;
    logic                  row_above [MAX_W];
    logic                  two_above [MAX_W];
    logic [8:0]            window_bits   = '0;
    int                    col_at        = 0;
    int                    row_at        = 0;
    logic [COUNT_W-1:0]    frame_matches = '0;

    t_window_result expected_q[$];
    logic           pixel_q[$];
    logic           frame_img [MAX_W][MAX_W];

    int   send_gap_max = 0;
    int   recv_gap_max = 0;
    int   tx_wait      = 0;
    int   rx_wait      = 0;
    int   rx_left;
    logic long_hold    = 1'b0;
    logic hold_armed   = 1'b0;

    int mismatches   = 0;
    int pixels_taken = 0;
    int frames_seen  = 0;
    int hits_seen    = 0;
    int reg_writes   = 0;
    int cycles       = 0;

    binary_window_template_counter_top #(.MAX_WIDTH(MAX_W)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_window_match (o_window_match),
        .o_match_count  (o_match_count),
        .o_frame_done   (o_frame_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Size in use: out-of-range register values saturate
    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Advance the raster window by one pixel and queue the result it gives
    function automatic void advance_window(input logic px);
        int             w;
        int             h;
        logic           up1;
        logic           up2;
        t_window_result res;
        w   = clamp_size(width_mirror, MAX_W);
        h   = clamp_size(height_mirror, HEIGHT_LIMIT);
        up1 = row_above[col_at];
        up2 = two_above[col_at];
        two_above[col_at] = up1;
        row_above[col_at] = px;
        window_bits = {px, up1, up2, window_bits[8:3]};
        res.hit = (row_at >= 2) && (col_at >= 2) && (window_bits == tmpl_mirror);
        if (res.hit && frame_matches != COUNT_MAX) frame_matches++;
        res.count = frame_matches;
        res.last  = 1'b0;
        // A position at or past the last column or row ends it
        if (col_at + 1 >= w) begin
            col_at = 0;
            if (row_at + 1 >= h) begin
                res.last = 1'b1;
                row_at   = 0;
            end else begin
                row_at++;
            end
        end else begin
            col_at++;
        end
        if (res.last) frame_matches = '0;
        expected_q.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_beat();
        t_window_result want;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", COUNT_W'(1), COUNT_W'(0));
            return;
        end
        want = expected_q.pop_front();
        if (o_window_match !== want.hit)
            report_mismatch("window_match", COUNT_W'(o_window_match), COUNT_W'(want.hit));
        if (o_match_count !== want.count)
            report_mismatch("match_count", o_match_count, want.count);
        if (o_frame_done !== want.last)
            report_mismatch("frame_done", COUNT_W'(o_frame_done), COUNT_W'(want.last));
        if (want.hit) hits_seen++;
        if (want.last) frames_seen++;
    endtask

    // Pixel driver: hold a stalled beat, wait the drawn gap, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_window(i_pixel);
                pixels_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_wait > 0) begin
                    tx_wait <= tx_wait - 1;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_pixel <= pixel_q.pop_front();
                    tx_wait <= $urandom_range(0, send_gap_max);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each taken beat, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_left = (rx_wait > 0) ? rx_wait - 1 : 0;
            if (o_valid && !i_stall) begin
                check_beat();
                rx_left = $urandom_range(0, recv_gap_max);
            end
            rx_wait <= rx_left;
            i_stall <= long_hold || (rx_left != 0);
        end
    end

    // Long receiver hold-off while pixels keep coming, so the block backs up
    initial begin
        wait (hold_armed);
        repeat (50) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("[binary_window_template_counter_top] ERROR");
            $finish;
        end
    end

    // Wait until every pixel is taken and every result beat has arrived
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || i_valid || expected_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register over the config channel and mirror it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_TEMPLATE: tmpl_mirror   = data[TEMPLATE_W-1:0];
            REG_WIDTH:    width_mirror  = data[SIZE_W-1:0];
            REG_HEIGHT:   height_mirror = data[SIZE_W-1:0];
            default:      ;
        endcase
    endtask

    // Fill the image with background density dens8/8, then plant template copies
    task automatic paint_image(input int dens8, input int plants);
        int w;
        int h;
        int pr;
        int pc;
        w = clamp_size(width_mirror, MAX_W);
        h = clamp_size(height_mirror, HEIGHT_LIMIT);
        for (int r = 0; r < MAX_W; r++)
            for (int c = 0; c < MAX_W; c++)
                frame_img[r][c] = ($urandom_range(0, 7) < dens8);
        repeat (plants) begin
            pr = $urandom_range(0, h - 3);
            pc = $urandom_range(0, w - 3);
            for (int dc = 0; dc < 3; dc++)
                for (int dr = 0; dr < 3; dr++)
                    frame_img[pr + dr][pc + dc] = tmpl_mirror[3 * dc + dr];
        end
    endtask

    // Queue n pixels from the image, following the raster from the current position
    task automatic queue_phase(input int n);
        int w;
        int h;
        int r;
        int c;
        w = clamp_size(width_mirror, MAX_W);
        h = clamp_size(height_mirror, HEIGHT_LIMIT);
        r = row_at;
        c = col_at;
        for (int k = 0; k < n; k++) begin
            pixel_q.push_back(frame_img[r][c]);
            if (c + 1 >= w) begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                c++;
            end
        end
        wait_idle();
    endtask

    // Size value: mostly small, sometimes the largest or out of range; junk upper bits
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        logic [SIZE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 7'($urandom_range(0, 2));
            1:       v = 7'($urandom_range(65, 127));
            2:       v = 7'd64;
            default: v = 7'($urandom_range(3, 10));
        endcase
        return {2'($urandom_range(0, 3)), v};
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // Change some registers between phases; widen only on the first row of a frame
    task automatic shuffle_config();
        logic [CFG_DATA_W-1:0] d;
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
                0:       d = '0;
                1:       d = '1;
                default: d = 9'($urandom_range(0, 511));
            endcase
            write_reg(REG_TEMPLATE, d);
        end
        if ($urandom_range(0, 2) == 0) begin
            d = pick_size();
            if (row_at == 0 ||
                clamp_size(d[SIZE_W-1:0], MAX_W) <= clamp_size(width_mirror, MAX_W))
                write_reg(REG_WIDTH, d);
        end
        if ($urandom_range(0, 2) == 0) write_reg(REG_HEIGHT, pick_size());
        if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 9'($urandom_range(0, 511)));
    endtask

    initial begin
        int random_left;
        int n;
        for (int k = 0; k < MAX_W; k++) begin
            row_above[k] = 1'b0;
            two_above[k] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest frame, all-ones template over an all-ones image
        write_reg(REG_WIDTH, 9'd3);
        write_reg(REG_HEIGHT, 9'd3);
        write_reg(REG_TEMPLATE, 9'h1FF);
        paint_image(8, 0);
        queue_phase(9);

        // Sizes below range saturate to 3; the spare index changes nothing
        write_reg(REG_SPARE, 9'h1FF);
        write_reg(REG_WIDTH, {2'b11, 7'd2});
        write_reg(REG_HEIGHT, {2'b10, 7'd0});
        write_reg(REG_TEMPLATE, '0);
        paint_image(0, 0);
        queue_phase(9);

        // Shrink the width mid-row: the current column becomes the last one
        send_gap_max = 12;
        recv_gap_max = 12;
        write_reg(REG_WIDTH, 9'd6);
        write_reg(REG_HEIGHT, {2'b01, 7'd2});
        write_reg(REG_TEMPLATE, 9'b010_111_010);
        paint_image(4, 2);
        queue_phase(3);
        write_reg(REG_WIDTH, 9'd3);
        queue_phase(7);

        // Full-width frame, empty image, empty template: every complete window
        // matches, with a long receiver hold-off in the middle
        send_gap_max = 0;
        recv_gap_max = 0;
        write_reg(REG_WIDTH, 9'd64);
        write_reg(REG_HEIGHT, 9'(WIDE_ROWS));
        write_reg(REG_TEMPLATE, '0);
        paint_image(0, 0);
        hold_armed = 1'b1;
        queue_phase(MAX_W * WIDE_ROWS);

        // Random phases: planted templates over random backgrounds, random sizes and gaps
        random_left = RANDOM_PIXELS;
        while (random_left > 0) begin
            shuffle_config();
            send_gap_max = pick_gap();
            recv_gap_max = pick_gap();
            paint_image($urandom_range(0, 8), $urandom_range(0, 30));
            n = $urandom_range(1, 120);
            if (n > random_left) n = random_left;
            queue_phase(n);
            random_left -= n;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("run covered %0d pixels, %0d complete frames, %0d window matches,",
                 pixels_taken, frames_seen, hits_seen);
        $display("%0d register writes and %0d mismatching fields", reg_writes, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("[binary_window_template_counter_top] OK");
        end else begin
            $display("[binary_window_template_counter_top] ERROR");
        end
        $finish;
    end

endmodule
